[rtl/fpcc_pkg.sv]
// package for the frame payload ctr cipher: payload structs, sbox, aes helpers
// no dependencies
package fpcc_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned CfgAddrW = 4;

  typedef enum logic [0:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_idx_t;

  // back end states: waiting, running aes rounds, keystream block held
  typedef enum logic [1:0] { B_IDLE, B_RUN, B_HAVE } bst_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        dir_down;
    logic [31:0] node_addr;
    logic [31:0] frame_counter;
    logic        last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
  } out_item_t;

  // one queued item: byte, its block position and, at block start, the counter block
  typedef struct packed {
    logic [7:0]   data_byte;
    logic         last_in;
    logic [3:0]   pos;
    logic         blk_start;
    logic [127:0] ctr_blk;
  } q_item_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit block sits at bits 127-8i
  function automatic logic [7:0] get_b(input logic [127:0] v, input int i);
    get_b = v[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        t[127-8*(j+4*c) -: 8] = SBOX[get_b(s, j + 4*((c + j) % 4))];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] t);
    logic [127:0] m;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(t, 4*c);
      a1 = get_b(t, 4*c+1);
      a2 = get_b(t, 4*c+2);
      a3 = get_b(t, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      m[127-8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      m[127-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      m[127-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      m[127-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    mix_cols = m;
  endfunction

  function automatic logic [127:0] next_rkey(input logic [127:0] k, input logic [7:0] rcon);
    logic [31:0] w0, w1, w2, w3, tw;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    tw = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ tw;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_rkey = {w0, w1, w2, w3};
  endfunction

endpackage

[rtl/fpcc_front.sv]
// front end: accepts payload bytes, tracks block position and index, builds counter block
// depends on fpcc_pkg
module fpcc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fpcc_pkg::in_item_t in_data,
  output logic               q_push,
  output fpcc_pkg::q_item_t  q_item,
  input  logic               q_full
);
  import fpcc_pkg::*;

  logic [3:0] pos_r, pos_nxt;
  logic [7:0] blk_idx_r, blk_idx_nxt;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_item.data_byte = in_data.data_byte;
    q_item.last_in   = in_data.last_in;
    q_item.pos       = pos_r;
    q_item.blk_start = (pos_r == 4'd0);
    q_item.ctr_blk   = {8'h01, 32'h0, 7'h0, in_data.dir_down,
                        in_data.node_addr[7:0], in_data.node_addr[15:8],
                        in_data.node_addr[23:16], in_data.node_addr[31:24],
                        in_data.frame_counter[7:0], in_data.frame_counter[15:8],
                        in_data.frame_counter[23:16], in_data.frame_counter[31:24],
                        8'h00, blk_idx_r};
    pos_nxt     = pos_r;
    blk_idx_nxt = blk_idx_r;
    if (q_push) begin
      if (in_data.last_in) begin
        pos_nxt     = 4'd0;
        blk_idx_nxt = 8'd1;
      end else begin
        pos_nxt = pos_r + 4'd1;
        if (pos_r == 4'hf) blk_idx_nxt = blk_idx_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      blk_idx_r <= 8'd1;
    end else begin
      pos_r     <= pos_nxt;
      blk_idx_r <= blk_idx_nxt;
    end
  end
endmodule

[rtl/fpcc_queue.sv]
// small fifo between front and back ends
// depends on fpcc_pkg
module fpcc_queue #(
  parameter int unsigned Depth = fpcc_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fpcc_pkg::q_item_t push_item,
  output logic              full,
  input  logic              pop,
  output fpcc_pkg::q_item_t head,
  output logic              not_empty
);
  import fpcc_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  q_item_t        mem_r [Depth];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;

  assign full      = (cnt_r == (AW+1)'(Depth));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rp_r];

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    inc = (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= inc(wp_r);
      if (pop)  rp_r <= inc(rp_r);
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

[rtl/fpcc_back.sv]
// back end: iterative aes-128 round unit and keystream xor with output register
// depends on fpcc_pkg
module fpcc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [127:0]       key,
  input  logic               q_not_empty,
  input  fpcc_pkg::q_item_t  q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output fpcc_pkg::out_item_t out_data
);
  import fpcc_pkg::*;

  bst_t         st_r, st_nxt;
  logic [127:0] s_r, s_nxt, rk_r, rk_nxt, ks_r, ks_nxt;
  logic [7:0]   rcon_r, rcon_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic         ov_r, ov_nxt;
  out_item_t    od_r, od_nxt;
  logic [127:0] ss, nrk;
  logic         can_emit;

  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign can_emit  = !ov_r || out_ready;

  always_comb begin
    st_nxt   = st_r;
    s_nxt    = s_r;
    rk_nxt   = rk_r;
    ks_nxt   = ks_r;
    rcon_nxt = rcon_r;
    rnd_nxt  = rnd_r;
    ov_nxt   = ov_r && !out_ready;
    od_nxt   = od_r;
    q_pop    = 1'b0;
    nrk      = next_rkey(rk_r, rcon_r);
    ss       = sub_shift(s_r);
    unique case (st_r)
      B_IDLE, B_HAVE: begin
        if (q_not_empty) begin
          if (q_head.blk_start) begin
            // start a keystream block: initial add round key
            s_nxt    = q_head.ctr_blk ^ key;
            rk_nxt   = key;
            rcon_nxt = 8'h01;
            rnd_nxt  = 4'd1;
            st_nxt   = B_RUN;
          end else if (can_emit && st_r == B_HAVE) begin
            q_pop  = 1'b1;
            ov_nxt = 1'b1;
            od_nxt.out_byte = q_head.data_byte ^ ks_r[127-8*q_head.pos -: 8];
            od_nxt.last_out = q_head.last_in;
          end
        end
      end
      B_RUN: begin
        rk_nxt   = nrk;
        rcon_nxt = xtime(rcon_r);
        rnd_nxt  = rnd_r + 4'd1;
        if (rnd_r == 4'd10) begin
          ks_nxt = ss ^ nrk;
          st_nxt = B_HAVE;
        end else begin
          s_nxt = mix_cols(ss) ^ nrk;
        end
        // once finished the head (block start) is emitted from the held keystream when the output can take it
      end
      default: st_nxt = B_IDLE;
    endcase
    // block-start byte is emitted after its keystream is ready; mark it consumed
    if (st_r == B_HAVE && q_not_empty && q_head.blk_start && rnd_r == 4'd11 && can_emit) begin
      st_nxt  = B_HAVE;
      s_nxt   = s_r;
      rk_nxt  = rk_r;
      rnd_nxt = 4'd0;
      q_pop   = 1'b1;
      ov_nxt  = 1'b1;
      od_nxt.out_byte = q_head.data_byte ^ ks_r[127 -: 8];
      od_nxt.last_out = q_head.last_in;
    end else if (st_r == B_HAVE && q_not_empty && q_head.blk_start && rnd_r == 4'd11) begin
      st_nxt  = B_HAVE;
      s_nxt   = s_r;
      rk_nxt  = rk_r;
      rnd_nxt = rnd_r;
    end
  end

  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    rk_r   <= rk_nxt;
    ks_r   <= ks_nxt;
    rcon_r <= rcon_nxt;
    od_r   <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= B_IDLE;
      rnd_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      rnd_r <= rnd_nxt;
      ov_r  <= ov_nxt;
    end
  end
endmodule

[rtl/frame_payload_ctr_cipher.sv]
// throughput: one byte per cycle within a block unless out_ready stalls; a block start waits for
// the iterative aes round unit (load, then one round per cycle), the queue absorbs bursts
// reset: rst_n synchronous active low clears position, block index 1, key to zero
// depends on fpcc_pkg, fpcc_front, fpcc_queue, fpcc_back
module frame_payload_ctr_cipher #(
  parameter int unsigned QDepth = fpcc_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fpcc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fpcc_pkg::out_item_t  out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [fpcc_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [63:0]          cfg_pwdata,
  output logic [63:0]          cfg_prdata,
  output logic                 cfg_pready
);
  import fpcc_pkg::*;

  logic [63:0] key_hi_r, key_lo_r;
  logic        q_push, q_full, q_pop, q_ne;
  q_item_t     q_in, q_head;
  reg_idx_t    ridx;

  // registers at 8-byte spacing
  assign ridx       = reg_idx_t'(cfg_paddr[3]);
  assign cfg_pready = 1'b1;

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2:0] == 3'd0) begin
      unique case (ridx)
        REG_KEY_HIGH: cfg_prdata = key_hi_r;
        REG_KEY_LOW:  cfg_prdata = key_lo_r;
        default:      cfg_prdata = '0;
      endcase
    end
  end

  // key write on the access phase of a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2:0] == 3'd0) begin
      if (ridx == REG_KEY_HIGH) key_hi_r <= cfg_pwdata;
      else                      key_lo_r <= cfg_pwdata;
    end
  end

  fpcc_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_push, .q_item(q_in), .q_full
  );

  fpcc_queue #(.Depth(QDepth)) u_queue (
    .clk, .rst_n, .push(q_push), .push_item(q_in), .full(q_full),
    .pop(q_pop), .head(q_head), .not_empty(q_ne)
  );

  fpcc_back u_back (
    .clk, .rst_n, .key({key_hi_r, key_lo_r}), .q_not_empty(q_ne), .q_head,
    .q_pop, .out_valid, .out_ready, .out_data
  );
endmodule
